// ===== src/grid_area_of_interest_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Grid area-of-interest engine assertion macros
// Implication checks on clk, disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GRID_AREA_OF_INTEREST_ENGINE_ASSERT_SVH
`define GRID_AREA_OF_INTEREST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define GAOI_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gaoi: same-cycle check failed");
`define GAOI_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gaoi: next-cycle check failed");
`else
`define GAOI_ASSERT_IMP(name, ante, cons)
`define GAOI_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== src/gaoi_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid area-of-interest package
// Item and result types, controller interface structs and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gaoi_pkg;

	localparam int POS_W     = 24;
	localparam int REACH_W   = 23;
	localparam int ID_W      = 10;
	localparam int CELL_W    = 12;
	localparam int CNT_W     = 7;
	localparam int SIZE_W    = 23;
	localparam int NUM_W     = 25;
	localparam int DIV_W     = 24;
	localparam int DIV_STEPS = 24;
	localparam int STEP_W    = 5;
	localparam int IDX_W     = 2;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [IDX_W-1:0] REG_ACROSS = 2'd0;
	localparam logic [IDX_W-1:0] REG_DOWN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIZE   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_TRUNC   = 2'd3;

	localparam logic [CNT_W-1:0]  RST_ACROSS = 7'd64;
	localparam logic [CNT_W-1:0]  RST_DOWN   = 7'd64;
	localparam logic [SIZE_W-1:0] RST_SIZE   = 23'd4096;

	typedef struct packed {
		logic                      command;
		logic [ID_W-1:0]           entity_id;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic [REACH_W-1:0]        reach;
	} gaoi_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_id;
		logic [CELL_W-1:0] old_cell;
		logic              had_old;
		logic              moved;
		logic [1:0]        status;
		logic              last;
	} gaoi_result_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic step;
		logic bound;
		logic base;
		logic place;
		logic emit;
		logic empty;
	} gaoi_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic div_done;
		logic is_query;
		logic is_empty;
		logic emit_last;
	} gaoi_stat_t;

endpackage

// ===== src/gaoi_div.sv =====
// ----------------------------------------------------------------------------
// Grid area-of-interest divider lane
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaoi_div (
	input  logic                       clk,
	input  logic                       load,
	input  logic                       step,
	input  logic [gaoi_pkg::DIV_W-1:0]  dividend,
	input  logic [gaoi_pkg::SIZE_W-1:0] divisor,
	output logic [gaoi_pkg::DIV_W-1:0]  quot,
	output logic [gaoi_pkg::SIZE_W-1:0] rem
);
	import gaoi_pkg::*;

	logic [DIV_W-1:0]  quot_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [DIV_W-1:0]  trial;
	logic [DIV_W-1:0]  diff;
	logic              fits;

	assign trial = {rem_q, quot_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (load) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (step) begin
			// partial remainder stays below the divisor, so it fits SIZE_W
			rem_q  <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			quot_q <= {quot_q[DIV_W-2:0], fits};
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== src/gaoi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Grid area-of-interest controller
// Sequences reset clearing, division, bounds, place update and query emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaoi_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  gaoi_pkg::gaoi_stat_t   stat,
	output gaoi_pkg::gaoi_cmd_t    cmd,
	output logic                   busy
);
	import gaoi_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DIV   = 8'b0000_0100,
		S_BOUND = 8'b0000_1000,
		S_BASE  = 8'b0001_0000,
		S_PLACE = 8'b0010_0000,
		S_EMIT  = 8'b0100_0000,
		S_EMPTY = 8'b1000_0000
	} gaoi_state_t;

	gaoi_state_t state_q;
	gaoi_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (stat.div_done) begin
					state_d = S_BOUND;
				end
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d   = S_BASE;
			end
			S_BASE: begin
				cmd.base = 1'b1;
				if (!stat.is_query) begin
					state_d = S_PLACE;
				end else if (stat.is_empty) begin
					state_d = S_EMPTY;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_IDLE;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_last) begin
					state_d = S_IDLE;
				end
			end
			S_EMPTY: begin
				cmd.empty = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== src/gaoi_datapath.sv =====
// ----------------------------------------------------------------------------
// Grid area-of-interest datapath
// Config registers, four divider lanes, window bounds, entity store, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaoi_datapath #(
	parameter int MAX_ENTITIES = 1024,
	parameter int MAX_CELLS_X  = 64,
	parameter int MAX_CELLS_Y  = 64,
	parameter int MAX_SPAN     = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [gaoi_pkg::IDX_W-1:0]  wr_index,
	input  logic [gaoi_pkg::SIZE_W-1:0] wr_data,
	input  gaoi_pkg::gaoi_item_t        item,
	input  gaoi_pkg::gaoi_cmd_t         cmd,
	output gaoi_pkg::gaoi_stat_t        stat,
	output gaoi_pkg::gaoi_result_t      result,
	output logic                        valid
);
	import gaoi_pkg::*;

	localparam int AW = $clog2(MAX_ENTITIES);

	// configuration
	logic [CNT_W-1:0]  across_q;
	logic [CNT_W-1:0]  down_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  across_e;
	logic [CNT_W-1:0]  down_e;
	logic [SIZE_W-1:0] size_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q <= RST_ACROSS;
			down_q   <= RST_DOWN;
			size_q   <= RST_SIZE;
		end else if (wr_en) begin
			case (wr_index)
				REG_ACROSS: across_q <= wr_data[CNT_W-1:0];
				REG_DOWN:   down_q   <= wr_data[CNT_W-1:0];
				REG_SIZE:   size_q   <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (across_q == '0) begin
			across_e = CNT_W'(1);
		end else if (32'(across_q) > 32'(MAX_CELLS_X)) begin
			across_e = CNT_W'(MAX_CELLS_X);
		end else begin
			across_e = across_q;
		end
		if (down_q == '0) begin
			down_e = CNT_W'(1);
		end else if (32'(down_q) > 32'(MAX_CELLS_Y)) begin
			down_e = CNT_W'(MAX_CELLS_Y);
		end else begin
			down_e = down_q;
		end
		size_e = (size_q == '0) ? SIZE_W'(1) : size_q;
	end

	// numerators: lanes 0..3 are x low, x high (or entity id), y low, y high
	logic signed [NUM_W-1:0] px25;
	logic signed [NUM_W-1:0] py25;
	logic signed [NUM_W-1:0] r25;
	logic signed [NUM_W-1:0] num [4];
	logic [DIV_W-1:0]        dvd [4];
	logic [SIZE_W-1:0]       dvs [4];
	logic [DIV_W-1:0]        quot [4];
	logic [SIZE_W-1:0]       rem [4];
	logic [3:0]              neg_q;
	logic                    op_q;
	logic                    query;

	assign query = (item.command == CMD_QUERY);
	assign px25  = {item.pos_x[POS_W-1], item.pos_x};
	assign py25  = {item.pos_y[POS_W-1], item.pos_y};
	assign r25   = {2'b00, item.reach};

	always_comb begin
		num[0] = query ? px25 - r25 : px25;
		num[1] = px25 + r25;
		num[2] = query ? py25 - r25 : py25;
		num[3] = py25 + r25;
		for (int i = 0; i < 4; i++) begin
			// floor(n/d) = ~(~n / d) for negative n
			dvd[i] = num[i][NUM_W-1] ? ~num[i][DIV_W-1:0] : num[i][DIV_W-1:0];
			dvs[i] = size_e;
		end
		if (!query) begin
			// place: lane 1 reduces the entity id modulo the store depth
			dvd[1] = DIV_W'(item.entity_id);
			dvs[1] = SIZE_W'(MAX_ENTITIES);
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		gaoi_div u_div (
			.clk      (clk),
			.load     (cmd.load),
			.step     (cmd.step),
			.dividend (dvd[g]),
			.divisor  (dvs[g]),
			.quot     (quot[g]),
			.rem      (rem[g])
		);
	end

	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			op_q   <= CMD_PLACE;
		end else if (cmd.load) begin
			step_q <= '0;
			op_q   <= item.command;
		end else if (cmd.step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= {num[3][NUM_W-1], num[2][NUM_W-1],
				query & num[1][NUM_W-1], num[0][NUM_W-1]};
		end
	end

	// window bounds
	logic signed [NUM_W-1:0] fl [4];
	logic signed [NUM_W-1:0] lim_x;
	logic signed [NUM_W-1:0] lim_y;
	logic signed [NUM_W-1:0] x0c;
	logic signed [NUM_W-1:0] x1c;
	logic signed [NUM_W-1:0] y0c;
	logic signed [NUM_W-1:0] y1c;
	logic                    outside;
	logic                    empty;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			fl[i] = neg_q[i] ? ~{1'b0, quot[i]} : {1'b0, quot[i]};
		end
		lim_x   = {{(NUM_W-CNT_W){1'b0}}, across_e - CNT_W'(1)};
		lim_y   = {{(NUM_W-CNT_W){1'b0}}, down_e - CNT_W'(1)};
		x0c     = fl[0][NUM_W-1] ? '0 : fl[0];
		y0c     = fl[2][NUM_W-1] ? '0 : fl[2];
		x1c     = (fl[1] > lim_x) ? lim_x : fl[1];
		y1c     = (fl[3] > lim_y) ? lim_y : fl[3];
		outside = fl[0][NUM_W-1] | (fl[0] > lim_x) | fl[2][NUM_W-1] | (fl[2] > lim_y);
		empty   = (x0c > x1c) | (y0c > y1c);
	end

	logic [CNT_W-1:0]  x0_q;
	logic [CNT_W-1:0]  x1_q;
	logic [CNT_W-1:0]  y0_q;
	logic [CNT_W-1:0]  y1_q;
	logic [CNT_W-1:0]  x_q;
	logic [CNT_W-1:0]  y_q;
	logic              outside_q;
	logic              empty_q;
	logic              trunc_q;
	logic [AW-1:0]     addr_q;
	logic [CELL_W-1:0] base_q;
	logic [2*CNT_W-1:0] prod;
	logic [CNT_W-1:0]  span_x;
	logic [CNT_W-1:0]  span_y;
	logic              trunc_x;
	logic              trunc_y;

	assign prod    = y0_q * across_e;
	assign span_x  = x1_q - x0_q;
	assign span_y  = y1_q - y0_q;
	assign trunc_x = 32'(span_x) >= 32'(MAX_SPAN);
	assign trunc_y = 32'(span_y) >= 32'(MAX_SPAN);

	// entity store: {placed, cell}
	logic [CELL_W:0]   mem [MAX_ENTITIES];
	logic [CELL_W:0]   rd_q;
	logic [AW-1:0]     clr_q;
	logic [CELL_W-1:0] place_cell;
	logic [CELL_W-1:0] old_cell;
	logic              had;
	logic              moved;
	logic              place_wr;
	logic [CELL_W-1:0] emit_cell;
	logic              emit_last;

	assign place_cell = base_q + CELL_W'(x0_q);
	assign had        = rd_q[CELL_W];
	assign old_cell   = had ? rd_q[CELL_W-1:0] : '0;
	assign moved      = !had || (old_cell != place_cell);
	assign place_wr   = cmd.place && !outside_q && moved;
	assign emit_cell  = base_q + CELL_W'(x_q);
	assign emit_last  = (x_q == x1_q) && (y_q == y1_q);

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_q] <= '0;
		end else if (place_wr) begin
			mem[addr_q] <= {1'b1, place_cell};
		end
		if (cmd.bound) begin
			rd_q <= mem[rem[1][AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bound) begin
			x0_q      <= x0c[CNT_W-1:0];
			x1_q      <= x1c[CNT_W-1:0];
			y0_q      <= y0c[CNT_W-1:0];
			y1_q      <= y1c[CNT_W-1:0];
			outside_q <= outside;
			empty_q   <= empty;
			addr_q    <= rem[1][AW-1:0];
		end else if (cmd.base) begin
			base_q  <= prod[CELL_W-1:0];
			x_q     <= x0_q;
			y_q     <= y0_q;
			trunc_q <= trunc_x | trunc_y;
			// keep only the lowest MAX_SPAN columns and rows
			if (trunc_x) begin
				x1_q <= x0_q + CNT_W'(MAX_SPAN - 1);
			end
			if (trunc_y) begin
				y1_q <= y0_q + CNT_W'(MAX_SPAN - 1);
			end
		end else if (cmd.emit) begin
			if (x_q == x1_q) begin
				x_q    <= x0_q;
				y_q    <= y_q + CNT_W'(1);
				base_q <= base_q + CELL_W'(across_e);
			end else begin
				x_q <= x_q + CNT_W'(1);
			end
		end
	end

	// result register
	gaoi_result_t result_q;
	logic         valid_q;

	always_ff @(posedge clk) begin
		if (cmd.place) begin
			result_q.cell_id  <= outside_q ? '0 : place_cell;
			result_q.old_cell <= old_cell;
			result_q.had_old  <= had;
			result_q.moved    <= !outside_q && moved;
			result_q.status   <= outside_q ? ST_OUTSIDE : ST_OK;
			result_q.last     <= 1'b1;
		end else if (cmd.emit) begin
			result_q.cell_id  <= emit_cell;
			result_q.old_cell <= '0;
			result_q.had_old  <= 1'b0;
			result_q.moved    <= 1'b0;
			result_q.status   <= trunc_q ? ST_TRUNC : ST_OK;
			result_q.last     <= emit_last;
		end else if (cmd.empty) begin
			result_q.cell_id  <= '0;
			result_q.old_cell <= '0;
			result_q.had_old  <= 1'b0;
			result_q.moved    <= 1'b0;
			result_q.status   <= ST_EMPTY;
			result_q.last     <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.place | cmd.emit | cmd.empty;
		end
	end

	assign result = result_q;
	assign valid  = valid_q;

	assign stat.clear_done = (clr_q == AW'(MAX_ENTITIES - 1));
	assign stat.div_done   = (step_q == STEP_W'(DIV_STEPS - 1));
	assign stat.is_query   = (op_q == CMD_QUERY);
	assign stat.is_empty   = empty_q;
	assign stat.emit_last  = emit_last;

endmodule

// ===== src/grid_area_of_interest_engine.sv =====
// ----------------------------------------------------------------------------
// Grid area-of-interest engine
// Uniform grid binning: entity placement and clamped range queries.
//
//   channel  ports                      handshake
//   -------  -------------------------  ---------------------------------
//   input    start, busy, item          taken when start && !busy
//   output   valid, result              one cycle per result, no stall
//   config   wr_en, wr_index, wr_data   written when wr_en is high
//
// A place runs through the divide, bound, base and place states to its result;
// a query runs through divide, bound and base, then emits one cell per cycle
// (up to MAX_SPAN squared). Division uses the 24-step restoring divider lanes
// (four in parallel). The entity store is cleared after reset, with busy high.
// Results cannot be stalled; busy is low again in the cycle of the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_area_of_interest_engine_assert.svh"

module grid_area_of_interest_engine #(
	parameter int MAX_ENTITIES = 1024,
	parameter int MAX_CELLS_X  = 64,
	parameter int MAX_CELLS_Y  = 64,
	parameter int MAX_SPAN     = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  gaoi_pkg::gaoi_item_t        item,
	output logic                        valid,
	output gaoi_pkg::gaoi_result_t      result,
	input  logic                        wr_en,
	input  logic [gaoi_pkg::IDX_W-1:0]  wr_index,
	input  logic [gaoi_pkg::SIZE_W-1:0] wr_data
);
	import gaoi_pkg::*;

	gaoi_cmd_t  cmd;
	gaoi_stat_t stat;

	gaoi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	gaoi_datapath #(
		.MAX_ENTITIES (MAX_ENTITIES),
		.MAX_CELLS_X  (MAX_CELLS_X),
		.MAX_CELLS_Y  (MAX_CELLS_Y),
		.MAX_SPAN     (MAX_SPAN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result),
		.valid    (valid)
	);

	// a result is the last of its item exactly when the engine is idle again
	`GAOI_ASSERT_IMP(a_last_frees, valid, busy == !result.last)
	// an empty window gives a single result
	`GAOI_ASSERT_IMP(a_empty_last, valid && result.status == ST_EMPTY, result.last)
	// an accepted item holds the engine and shows no result in the next cycle
	`GAOI_ASSERT_NXT(a_take_holds, start && !busy, busy && !valid)

endmodule
